>>> design/sha1_pkg.sv
package sha1_pkg;

    // SHA-1 initial chaining value
    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Round constants, one per group of twenty rounds
    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam int BLOCK_BITS  = 512;
    localparam int WORD_BITS   = 32;
    localparam int BYTE_BITS   = 8;

    // Block fill positions (byte count before the push)
    localparam logic [5:0] FILL_LAST    = 6'd63;
    localparam logic [5:0] FILL_PRE_LEN = 6'd55;

    // Round counter positions
    localparam logic [6:0] RND_G1   = 7'd20;
    localparam logic [6:0] RND_G2   = 7'd40;
    localparam logic [6:0] RND_G3   = 7'd60;
    localparam logic [6:0] RND_LAST = 7'd79;

    localparam logic [2:0] WORD_LAST = 3'd4;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       byte_present;
        logic       end_of_message;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_last;
    } dig_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

endpackage

>>> design/sha1_message_hasher.sv
// Channel  | Dir | Handshake            | Payload
// ---------+-----+----------------------+-------------------------------------
// msg      | in  | msg_valid/msg_ready  | message_byte, byte_present, end_of_message
// dig      | out | dig_valid/dig_ready  | digest_word, word_index, digest_last
//
// A byte item that neither ends the message nor fills a block leaves msg_ready high;
// the item that fills a 64-byte block adds a compression (80 rounds on the shared
// round adder, then the chaining add). An end item pads one byte per cycle up to the
// length field, then writes the 8 length bytes, with up to two compressions along the
// way, then presents the five digest words one per cycle while dig_ready is high.
// msg_ready is low from the accepted item until that work is done; a stalled dig
// channel holds the current word. rst_n clears all control state and the chain.
module sha1_message_hasher (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                msg_valid,
    output logic                msg_ready,
    input  sha1_pkg::msg_item_t msg,
    output logic                dig_valid,
    input  logic                dig_ready,
    output sha1_pkg::dig_item_t dig
);
    import sha1_pkg::*;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    logic [BLOCK_BITS-1:0] block_reg;
    logic [5:0]            fill_reg;
    logic [63:0]           count_reg;
    logic [6:0]            rnd_reg;
    logic [2:0]            idx_reg;
    logic [31:0]           h_reg [5];
    logic [31:0]           a_reg, b_reg, c_reg, d_reg, e_reg;

    logic       push_en;
    logic [7:0] push_byte;
    logic       count_en;
    logic       len_shift;
    logic       round_run;
    logic       add_en;
    logic       out_acc;
    logic       start_round;
    logic       done_msg;

    logic [31:0] w0, w2, w8, w13, w_mix;
    logic [31:0] f_val, k_val, t_val;

    // Schedule taps: window word j holds w[t+j], word 0 at the top
    assign w0    = block_reg[BLOCK_BITS-1 -: WORD_BITS];
    assign w2    = block_reg[BLOCK_BITS-1-2*WORD_BITS -: WORD_BITS];
    assign w8    = block_reg[BLOCK_BITS-1-8*WORD_BITS -: WORD_BITS];
    assign w13   = block_reg[BLOCK_BITS-1-13*WORD_BITS -: WORD_BITS];
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;

    // Round function and constant
    always_comb
    begin
        if (rnd_reg < RND_G1)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_0;
        end
        else if (rnd_reg < RND_G2)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_1;
        end
        else if (rnd_reg < RND_G3)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_3;
        end
    end

    // Shared round adder
    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w0;

    assign start_round = push_en && (fill_reg == FILL_LAST);
    assign done_msg    = out_acc && (idx_reg == WORD_LAST);

    // Sequencer: next state and control
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        push_en    = 1'b0;
        push_byte  = '0;
        count_en   = 1'b0;
        len_shift  = 1'b0;
        round_run  = 1'b0;
        add_en     = 1'b0;
        out_acc    = 1'b0;
        msg_ready  = (state_reg == ST_IDLE);
        dig_valid  = (state_reg == ST_OUT);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    if (msg.byte_present)
                    begin
                        push_en   = 1'b1;
                        push_byte = msg.message_byte;
                        count_en  = 1'b1;
                    end
                    if (msg.byte_present && (fill_reg == FILL_LAST))
                    begin
                        state_next = ST_ROUND;
                        ret_next   = msg.end_of_message ? ST_PAD_MARK : ST_IDLE;
                    end
                    else
                    begin
                        state_next = msg.end_of_message ? ST_PAD_MARK : ST_IDLE;
                    end
                end
            end
            ST_PAD_MARK:
            begin
                push_en   = 1'b1;
                push_byte = PAD_MARK;
                if (fill_reg == FILL_LAST)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_PAD_ZERO;
                end
                else if (fill_reg == FILL_PRE_LEN)
                begin
                    state_next = ST_PAD_LEN;
                end
                else
                begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO:
            begin
                push_en = 1'b1;
                if (fill_reg == FILL_LAST)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_PAD_ZERO;
                end
                else if (fill_reg == FILL_PRE_LEN)
                begin
                    state_next = ST_PAD_LEN;
                end
            end
            ST_PAD_LEN:
            begin
                push_en   = 1'b1;
                push_byte = count_reg[63:56];
                len_shift = 1'b1;
                if (fill_reg == FILL_LAST)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_OUT;
                end
            end
            ST_ROUND:
            begin
                round_run = 1'b1;
                if (rnd_reg == RND_LAST)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                add_en     = 1'b1;
                state_next = ret_reg;
            end
            ST_OUT:
            begin
                if (dig_ready)
                begin
                    out_acc = 1'b1;
                    if (idx_reg == WORD_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    // Block buffer doubles as the schedule window
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            block_reg <= {block_reg[BLOCK_BITS-BYTE_BITS-1:0], push_byte};
        end
        else if (round_run)
        begin
            block_reg <= {block_reg[BLOCK_BITS-WORD_BITS-1:0], w_mix[30:0], w_mix[31]};
        end
    end

    // Working variables
    always_ff @(posedge clk)
    begin
        if (start_round)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (round_run)
        begin
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // Counters and chaining value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            count_reg <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            for (int i = 0; i < 5; i++)
            begin
                h_reg[i] <= H_INIT[i];
            end
        end
        else
        begin
            if (push_en)
            begin
                fill_reg <= fill_reg + 6'd1;
            end

            if (done_msg)
            begin
                count_reg <= '0;
            end
            else if (count_en)
            begin
                count_reg <= count_reg + 64'd8;
            end
            else if (len_shift)
            begin
                count_reg <= {count_reg[55:0], 8'h00};
            end

            if (start_round)
            begin
                rnd_reg <= '0;
            end
            else if (round_run)
            begin
                rnd_reg <= rnd_reg + 7'd1;
            end

            if (out_acc)
            begin
                idx_reg <= (idx_reg == WORD_LAST) ? 3'd0 : idx_reg + 3'd1;
            end

            if (done_msg)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    h_reg[i] <= H_INIT[i];
                end
            end
            else if (add_en)
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
            end
        end
    end

    // Digest word output
    always_comb
    begin
        dig.digest_word = '0;
        unique case (idx_reg)
            3'd0:    dig.digest_word = h_reg[0];
            3'd1:    dig.digest_word = h_reg[1];
            3'd2:    dig.digest_word = h_reg[2];
            3'd3:    dig.digest_word = h_reg[3];
            3'd4:    dig.digest_word = h_reg[4];
            default: dig.digest_word = '0;
        endcase
        dig.word_index  = idx_reg;
        dig.digest_last = (idx_reg == WORD_LAST);
    end

endmodule
